[sv/modular_exponentiation_assert.svh]
// Assertion macros shared by the modular exponentiation RTL.
// Included by each module that carries concurrent checks; no dependencies.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/me_pkg.sv]
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by me_modmul and modular_exponentiation.
package me_pkg;

	localparam int DATA_W           = 32;
	localparam int OPERAND_BITS_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_DISPATCH,
		ST_MUL,
		ST_SQR,
		ST_OUT
	} me_state_t;

	// Request from the sequencer to the serial multiplier.
	typedef struct packed {
		logic start;
		logic wrap;
	} mm_ctrl_t;

	// Status returned by the serial multiplier.
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

[sv/modular_exponentiation.sv]
// Each item reduces the base, then takes one product per set exponent bit and one squaring per
// bit below the highest set bit.
// Throughput: one beat at a time; busy stays high from acceptance until done pulses.
// The single bit-serial modular multiplier does all of these products, one multiplier bit per cycle.
// Reset (arst_n low, asynchronous) returns to idle and sets the modulus register to 1.
// Done is high for one cycle; power_result holds the result until the next one. The receiver cannot stall.
`include "modular_exponentiation_assert.svh"

module modular_exponentiation
	import me_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              modulus_we,
	input  logic [DATA_W-1:0] modulus,
	input  logic              start,
	input  logic [DATA_W-1:0] base_value,
	input  logic [DATA_W-1:0] exponent,
	output logic              busy,
	output logic              done,
	output logic [DATA_W-1:0] power_result
);

	// Registered state. The exponent register shifts right after each squaring,
	// so its low bit always decides the next operation.
	me_state_t               state_q;
	me_state_t               state_d;
	logic [DATA_W-1:0]       modulus_q;
	logic [OPERAND_BITS-1:0] exp_q;
	logic [OPERAND_BITS-1:0] b_q;
	logic [OPERAND_BITS-1:0] acc_q;
	logic [OPERAND_BITS-1:0] result_q;
	logic                    done_q;

	// Multiplier hookup.
	mm_ctrl_t                mm_ctrl;
	mm_stat_t                mm_stat;
	logic [OPERAND_BITS-1:0] mm_mplier;
	logic [OPERAND_BITS-1:0] mm_mcand;
	logic [OPERAND_BITS-1:0] mm_product;
	logic [OPERAND_BITS-1:0] mod_n;
	logic                    accept;

	localparam logic [OPERAND_BITS-1:0] ONE = {{(OPERAND_BITS-1){1'b0}}, 1'b1};

	// Only the low operand bits of the modulus take part. A zero modulus makes
	// every reduction keep the low operand bits, which is plain wrapping.
	assign mod_n  = modulus_q[OPERAND_BITS-1:0];
	assign accept = start && (state_q == ST_IDLE);

	// Next-state logic. After the base is reduced, the dispatch state looks at
	// the remaining exponent: nothing left ends the item, a set low bit multiplies
	// the accumulator by the current base power, and a clear low bit squares that power.
	// A multiply clears the low bit, so the square for that bit follows, except
	// when no higher bit remains, where the square would be wasted.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (mm_stat.done) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (exp_q == '0) begin
					state_d = ST_OUT;
				end else if (exp_q[0]) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_SQR;
				end
			end
			ST_MUL, ST_SQR: begin
				if (mm_stat.done) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_OUT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output logic: multiplier launch and operand selection. The base reduction
	// is a product of the base with one, launched on the accepting edge.
	always_comb begin
		mm_ctrl.start = 1'b0;
		mm_ctrl.wrap  = (mod_n == '0);
		mm_mplier     = b_q;
		mm_mcand      = b_q;
		case (state_q)
			ST_IDLE: begin
				mm_ctrl.start = start;
				mm_mplier     = base_value[OPERAND_BITS-1:0];
				mm_mcand      = ONE;
			end
			ST_DISPATCH: begin
				mm_ctrl.start = (exp_q != '0);
				if (exp_q[0]) begin
					mm_mplier = acc_q;
				end
			end
			default: begin
				mm_ctrl.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			modulus_q <= DATA_W'(1);
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_OUT);
			if (modulus_we) begin
				modulus_q <= modulus;
			end
		end
	end

	// Datapath. The accumulator starts at one and is left unreduced when the
	// exponent is zero, so that case yields one even for a modulus of one.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					exp_q <= exponent[OPERAND_BITS-1:0];
					acc_q <= ONE;
				end
			end
			ST_REDUCE: begin
				if (mm_stat.done) begin
					b_q <= mm_product;
				end
			end
			ST_MUL: begin
				if (mm_stat.done) begin
					acc_q    <= mm_product;
					exp_q[0] <= 1'b0;
				end
			end
			ST_SQR: begin
				if (mm_stat.done) begin
					b_q   <= mm_product;
					exp_q <= exp_q >> 1;
				end
			end
			ST_OUT: begin
				result_q <= acc_q;
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	me_modmul #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mm_ctrl),
		.mplier (mm_mplier),
		.mcand  (mm_mcand),
		.modulus(mod_n),
		.stat   (mm_stat),
		.product(mm_product)
	);

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign power_result = DATA_W'(result_q);

	`ME_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy, "accepted beat did not raise busy")
	`ME_ASSERT_NOW(a_done_idle, clk, arst_n, done_q, state_q == ST_IDLE, "result beat outside idle")
	`ME_ASSERT_NOW(a_mm_free, clk, arst_n, mm_ctrl.start, !mm_stat.busy, "multiplier launched while busy")
	`ME_ASSERT_NOW(a_mm_owner, clk, arst_n, mm_stat.done, state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR, "product returned with no operation pending")

endmodule

[sv/me_modmul.sv]
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// Depends on me_pkg and modular_exponentiation_assert.svh.
`include "modular_exponentiation_assert.svh"

module me_modmul
	import me_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mm_ctrl_t                ctrl,
	input  logic [OPERAND_BITS-1:0] mplier,
	input  logic [OPERAND_BITS-1:0] mcand,
	input  logic [OPERAND_BITS-1:0] modulus,
	output mm_stat_t                stat,
	output logic [OPERAND_BITS-1:0] product
);

	localparam int W  = OPERAND_BITS + 2;
	localparam int CW = $clog2(OPERAND_BITS);

	logic [OPERAND_BITS-1:0] a_q;
	logic [OPERAND_BITS-1:0] b_q;
	logic [OPERAND_BITS-1:0] m_q;
	logic [OPERAND_BITS-1:0] r_q;
	logic                    wrap_q;
	logic [CW-1:0]           cnt_q;
	logic                    run_q;
	logic                    done_q;

	logic [W-1:0]            t;
	logic [W:0]              d1;
	logic [W:0]              d2;
	logic [OPERAND_BITS-1:0] r_next;

	// Double the partial remainder and add the multiplicand when the top bit is set.
	// The sum stays below three times the modulus, so at most one of the two
	// candidate subtractions is needed.
	always_comb begin
		t  = {1'b0, r_q, 1'b0} + (a_q[OPERAND_BITS-1] ? {2'b00, b_q} : W'(0));
		d1 = {1'b0, t} - {3'b000, m_q};
		d2 = {1'b0, t} - {2'b00, m_q, 1'b0};
		if (wrap_q) begin
			r_next = t[OPERAND_BITS-1:0];
		end else if (!d2[W]) begin
			r_next = d2[OPERAND_BITS-1:0];
		end else if (!d1[W]) begin
			r_next = d1[OPERAND_BITS-1:0];
		end else begin
			r_next = t[OPERAND_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(OPERAND_BITS - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a_q    <= mplier;
			b_q    <= mcand;
			m_q    <= modulus;
			wrap_q <= ctrl.wrap;
			r_q    <= '0;
		end else if (run_q) begin
			a_q <= a_q << 1;
			r_q <= r_next;
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign product   = r_q;

	`ME_ASSERT_NOW(a_no_restart, clk, arst_n, ctrl.start, !run_q, "multiplier restarted while running")
	`ME_ASSERT_NEXT(a_done_ends, clk, arst_n, done_q, !run_q && !done_q, "done pulse not single")
	`ME_ASSERT_NOW(a_rem_bound, clk, arst_n, run_q && !wrap_q, r_q < m_q, "remainder out of range")

endmodule
